>>> hdl/kspl_pkg.sv
// Package: key codes, result codes, widths and keypad decode table for the PIN lock.
package kspl_pkg;

  localparam int PIN_LENGTH_DEF = 4;
  localparam int PIN_REGS       = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int DIGIT_W        = 4;
  localparam int KEY_W          = 5;
  localparam int EVENT_W        = 3;
  localparam int HELD_W         = 3;
  localparam int COL_W          = 2;
  localparam int DRIVE_W        = 4;
  localparam int SAMPLE_W       = 8;

  localparam logic [KEY_W-1:0]   KEY_STAR   = 5'd14;
  localparam logic [KEY_W-1:0]   KEY_NONE   = 5'd16;
  localparam logic [DRIVE_W-1:0] DRIVE_IDLE = 4'hF;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIN_FIRST  = 2'd0,
    CFG_PIN_SECOND = 2'd1,
    CFG_PIN_THIRD  = 2'd2,
    CFG_PIN_FOURTH = 2'd3
  } cfg_idx_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_STORED  = 3'd1,
    EV_FULL    = 3'd2,
    EV_GRANTED = 3'd3,
    EV_DENIED  = 3'd4
  } event_t;

  // Rows in the high nibble, columns in the low nibble, both active low.
  function automatic logic [KEY_W-1:0] decode_sample(input logic [SAMPLE_W-1:0] s);
    logic [KEY_W-1:0] k;
    begin
      unique case (s)
        8'h77:   k = 5'd1;
        8'hB7:   k = 5'd4;
        8'hD7:   k = 5'd7;
        8'hE7:   k = 5'd14;
        8'h7B:   k = 5'd2;
        8'hBB:   k = 5'd5;
        8'hDB:   k = 5'd8;
        8'hEB:   k = 5'd0;
        8'h7D:   k = 5'd3;
        8'hBD:   k = 5'd6;
        8'hDD:   k = 5'd9;
        8'hED:   k = 5'd15;
        8'h7E:   k = 5'd10;
        8'hBE:   k = 5'd11;
        8'hDE:   k = 5'd12;
        8'hEE:   k = 5'd13;
        default: k = KEY_NONE;
      endcase
      return k;
    end
  endfunction

  // Drive one column low: first column is the MSB of the nibble.
  function automatic logic [DRIVE_W-1:0] column_nibble(input logic [COL_W-1:0] c);
    logic [DRIVE_W-1:0] d;
    begin
      d = ~(4'b1000 >> c);
      return d;
    end
  endfunction

endpackage

>>> hdl/kspl_stream_if.sv
// Interfaces: valid/ready channels for keypad input items and lock result items.
interface kspl_in_if
  import kspl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] port_sample;

  modport source (output valid, output action, output port_sample, input ready);
  modport sink   (input valid, input action, input port_sample, output ready);
endinterface

interface kspl_out_if
  import kspl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] column_drive;
  logic [KEY_W-1:0]   key_code;
  logic [EVENT_W-1:0] event_res;
  logic [HELD_W-1:0]  keys_held;

  modport source (output valid, output column_drive, output key_code, output event_res,
                  output keys_held, input ready);
  modport sink   (input valid, input column_drive, input key_code, input event_res,
                  input keys_held, output ready);
endinterface

>>> hdl/keypad_scan_pin_lock.sv
// Top level: keypad column scanner, key decoder and PIN entry/compare lock.
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+-------------
//  in_ch    | in  | action, port_sample                           | valid/ready
//  out_ch   | out | column_drive, key_code, event_res, keys_held  | valid/ready
//  cfg_*    | in  | cfg_index selects PIN digit, cfg_wdata        | cfg_we only
//
//  Each transaction is decoded, compared and applied to the entry buffer in the
//  cycle it is accepted; its result sits in the output register the cycle after.
//  One transaction per unstalled cycle; the output register is the only stage.
//  in_ch.ready drops only while a result is held and out_ch.ready is low.
//  Synchronous active-low reset: column 0, empty buffer, PIN 1-2-3-4.
module keypad_scan_pin_lock
  import kspl_pkg::*;
#(
  parameter int PIN_LENGTH = PIN_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  kspl_in_if.sink              in_ch,
  kspl_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIGIT_W-1:0]   cfg_wdata
);

  logic [DIGIT_W-1:0] pin_r [PIN_REGS];
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [DIGIT_W-1:0] keys_r [PIN_LENGTH];
  logic [DIGIT_W-1:0] keys_nxt [PIN_LENGTH];
  logic [HELD_W-1:0]  count_r, count_nxt;

  logic               out_valid_r;
  logic [DRIVE_W-1:0] drive_r, drive_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  event_t             event_r, event_nxt;
  logic [HELD_W-1:0]  held_r;

  logic               accept;
  logic               match;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Full entry that equals the PIN; empty slots never match.
  always_comb begin
    match = (count_r == HELD_W'(PIN_LENGTH));
    for (int i = 0; i < PIN_LENGTH; i++) begin
      if (keys_r[i] != pin_r[i]) match = 1'b0;
    end
  end

  always_comb begin
    col_nxt   = col_r;
    count_nxt = count_r;
    for (int i = 0; i < PIN_LENGTH; i++) keys_nxt[i] = keys_r[i];
    drive_nxt = DRIVE_IDLE;
    key_nxt   = KEY_NONE;
    event_nxt = EV_NONE;
    if (in_ch.action == ACT_TICK) begin
      drive_nxt = column_nibble(col_r);
      col_nxt   = col_r + COL_W'(1);
    end else begin
      key_nxt = decode_sample(in_ch.port_sample);
      if (key_nxt == KEY_STAR) begin
        event_nxt = match ? EV_GRANTED : EV_DENIED;
        count_nxt = '0;
      end else if (key_nxt != KEY_NONE) begin
        if (count_r < HELD_W'(PIN_LENGTH)) begin
          for (int i = 0; i < PIN_LENGTH; i++) begin
            if (count_r == HELD_W'(i)) keys_nxt[i] = key_nxt[DIGIT_W-1:0];
          end
          count_nxt = count_r + HELD_W'(1);
          event_nxt = EV_STORED;
        end else begin
          event_nxt = EV_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r[CFG_PIN_FIRST]  <= DIGIT_W'(1);
      pin_r[CFG_PIN_SECOND] <= DIGIT_W'(2);
      pin_r[CFG_PIN_THIRD]  <= DIGIT_W'(3);
      pin_r[CFG_PIN_FOURTH] <= DIGIT_W'(4);
    end else if (cfg_we) begin
      pin_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r   <= col_nxt;
        count_r <= count_nxt;
      end
      if (accept) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload: buffer slots are qualified by count_r, result fields by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PIN_LENGTH; i++) keys_r[i] <= keys_nxt[i];
      drive_r <= drive_nxt;
      key_r   <= key_nxt;
      event_r <= event_nxt;
      held_r  <= count_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_drive = drive_r;
  assign out_ch.key_code     = key_r;
  assign out_ch.event_res    = event_r;
  assign out_ch.keys_held    = held_r;

endmodule
